[sv/ggd_pkg.sv]
// Shared types and constants for the gyro gesture detector.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ggd_pkg;

  // Width of one raw gyro rate
  localparam int unsigned RATE_BITS = 16;
  // Configuration threshold widths
  localparam int unsigned THR_BITS  = 15;
  localparam int unsigned LIM_BITS  = 10;
  localparam int unsigned MS_BITS   = 8;
  // Signed compare width: holds x - y, its magnitude and every threshold
  localparam int unsigned CMP_W = (RATE_BITS + 2 > THR_BITS + 1) ? RATE_BITS + 2 : THR_BITS + 1;

  // APB register map
  localparam int unsigned ADDR_BITS = 5;
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned IDX_BITS  = 3;
  localparam logic [IDX_BITS-1:0] REG_VERT_TRIG  = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_VERT_RET   = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_HORZ_TRIG  = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_HORZ_RET   = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_RELEASE    = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_QUIET_LIM  = 3'd5;

  // Reset values of the registers
  localparam logic [THR_BITS-1:0] VERT_TRIG_RST = 15'd55;
  localparam logic [THR_BITS-1:0] VERT_RET_RST  = 15'd25;
  localparam logic [THR_BITS-1:0] HORZ_TRIG_RST = 15'd40;
  localparam logic [THR_BITS-1:0] HORZ_RET_RST  = 15'd20;
  localparam logic [THR_BITS-1:0] RELEASE_RST   = 15'd20;
  localparam logic [LIM_BITS-1:0] QUIET_LIM_RST = 10'd100;

  // Gesture directions; opposite directions differ in the upper bit
  typedef enum logic [1:0] {
    DIR_UP = 2'd0,
    DIR_RT = 2'd1,
    DIR_DN = 2'd2,
    DIR_LT = 2'd3
  } dir_e;

  typedef struct packed {
    logic [THR_BITS-1:0] vertical_trigger;
    logic [THR_BITS-1:0] vertical_return;
    logic [THR_BITS-1:0] horizontal_trigger;
    logic [THR_BITS-1:0] horizontal_return;
    logic [THR_BITS-1:0] release_level;
    logic [LIM_BITS-1:0] rearm_quiet_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [RATE_BITS-1:0] rate_x;
    logic signed [RATE_BITS-1:0] rate_y;
    logic signed [RATE_BITS-1:0] rate_z;
    logic [MS_BITS-1:0]          delta_ms;
    logic                        suppress;
    logic                        sample_ok;
  } sample_t;

  typedef struct packed {
    logic       move_valid;
    logic [1:0] move_direction;
  } result_t;

  // Classified sample passed from front to back; ret is indexed by the
  // direction whose return swing it reports
  typedef struct packed {
    logic               ok;
    logic               suppress;
    logic               valid;
    dir_e               det;
    logic [3:0]         ret;
    logic               quiet;
    logic [MS_BITS-1:0] elapsed;
  } cls_t;

endpackage

`default_nettype wire

[sv/ggd_regs.sv]
// APB configuration registers of the gyro gesture detector.
// Depends on ggd_pkg for the register map and cfg_t.
`default_nettype none

module ggd_regs
  import ggd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg_o
);

  cfg_t                cfg_q;
  logic                wr_en;
  logic [IDX_BITS-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_BITS-1:2];
  assign cfg_o  = cfg_q;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vertical_trigger   <= VERT_TRIG_RST;
      cfg_q.vertical_return    <= VERT_RET_RST;
      cfg_q.horizontal_trigger <= HORZ_TRIG_RST;
      cfg_q.horizontal_return  <= HORZ_RET_RST;
      cfg_q.release_level      <= RELEASE_RST;
      cfg_q.rearm_quiet_limit  <= QUIET_LIM_RST;
    end else if (wr_en) begin
      case (idx)
        REG_VERT_TRIG: cfg_q.vertical_trigger   <= pwdata[THR_BITS-1:0];
        REG_VERT_RET:  cfg_q.vertical_return    <= pwdata[THR_BITS-1:0];
        REG_HORZ_TRIG: cfg_q.horizontal_trigger <= pwdata[THR_BITS-1:0];
        REG_HORZ_RET:  cfg_q.horizontal_return  <= pwdata[THR_BITS-1:0];
        REG_RELEASE:   cfg_q.release_level      <= pwdata[THR_BITS-1:0];
        REG_QUIET_LIM: cfg_q.rearm_quiet_limit  <= pwdata[LIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      REG_VERT_TRIG: prdata = DATA_BITS'(cfg_q.vertical_trigger);
      REG_VERT_RET:  prdata = DATA_BITS'(cfg_q.vertical_return);
      REG_HORZ_TRIG: prdata = DATA_BITS'(cfg_q.horizontal_trigger);
      REG_HORZ_RET:  prdata = DATA_BITS'(cfg_q.horizontal_return);
      REG_RELEASE:   prdata = DATA_BITS'(cfg_q.release_level);
      REG_QUIET_LIM: prdata = DATA_BITS'(cfg_q.rearm_quiet_limit);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[sv/ggd_front.sv]
// Front end: classifies one gyro sample into direction, return and quiet flags.
// Depends on ggd_pkg for sample_t, cfg_t and cls_t.
`default_nettype none

module ggd_front
  import ggd_pkg::*;
(
  input  sample_t sample_i,
  input  cfg_t    cfg_i,
  output cls_t    cls_o
);

  logic signed [CMP_W-1:0] x, y, z, h;
  logic signed [CMP_W-1:0] ax, ay, az, ah;
  logic signed [CMP_W-1:0] vt, vr, ht, hr, rl;
  logic                    valid_v, valid_h;

  // Widen rates and thresholds to one signed compare width
  assign x  = CMP_W'(sample_i.rate_x);
  assign y  = CMP_W'(sample_i.rate_y);
  assign z  = CMP_W'(sample_i.rate_z);
  assign h  = x - y;
  assign ax = x[CMP_W-1] ? -x : x;
  assign ay = y[CMP_W-1] ? -y : y;
  assign az = z[CMP_W-1] ? -z : z;
  assign ah = h[CMP_W-1] ? -h : h;

  assign vt = CMP_W'(cfg_i.vertical_trigger);
  assign vr = CMP_W'(cfg_i.vertical_return);
  assign ht = CMP_W'(cfg_i.horizontal_trigger);
  assign hr = CMP_W'(cfg_i.horizontal_return);
  assign rl = CMP_W'(cfg_i.release_level);

  // Vertical wins when z dominates, horizontal when x - y dominates
  assign valid_v = (az >= vt) && (az > ah);
  assign valid_h = (ah >= ht) && (ah > az);

  always_comb begin
    cls_o.ok       = sample_i.sample_ok;
    cls_o.suppress = sample_i.suppress;
    cls_o.valid    = valid_v | valid_h;
    cls_o.elapsed  = sample_i.delta_ms;
    if (valid_v) begin
      cls_o.det = (z > 0) ? DIR_UP : DIR_DN;
    end else if (valid_h) begin
      cls_o.det = h[CMP_W-1] ? DIR_LT : DIR_RT;
    end else begin
      cls_o.det = DIR_UP;
    end
    // Return swing opposite to each possible last direction
    cls_o.ret[DIR_UP] = z < -vr;
    cls_o.ret[DIR_DN] = z > vr;
    cls_o.ret[DIR_LT] = h > hr;
    cls_o.ret[DIR_RT] = h < -hr;
    cls_o.quiet = (ax < rl) && (ay < rl) && (az < rl);
  end

endmodule

`default_nettype wire

[sv/ggd_queue.sv]
// Two-entry queue of classified samples between front and back.
// Depends on ggd_pkg for cls_t.
`default_nettype none

module ggd_queue
  import ggd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cls_t      data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cls_t      data_o
);

  cls_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and count on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: ;
      endcase
    end
  end

  // Store entry
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

[sv/ggd_back.sv]
// Back end: gesture state machine and two-entry result queue.
// Depends on ggd_pkg for cls_t, cfg_t, result_t and dir_e.
`default_nettype none

module ggd_back
  import ggd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  wire logic cls_empty_i,
  input  cls_t      cls_i,
  output logic      cls_pop_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output result_t   result_o
);

  // Gesture state
  logic                armed_q, armed_d;
  logic                ret_seen_q, ret_seen_d;
  logic [LIM_BITS-1:0] quiet_q, quiet_d;
  dir_e                last_q, last_d;

  // Result queue
  result_t    res_mem_q [2];
  logic       res_wr_q, res_rd_q;
  logic [1:0] res_cnt_q;
  logic       res_pop;

  result_t             res;
  logic                step;
  logic                perp;
  logic [LIM_BITS:0]   q_sum;
  logic [LIM_BITS-1:0] q_sat;

  // Take a classified sample whenever the result queue has room
  assign step      = ~cls_empty_i && (res_cnt_q != 2'd2);
  assign cls_pop_o = step;
  assign res_pop   = pop_i & ~empty_o;
  assign empty_o   = res_cnt_q == 2'd0;
  assign result_o  = res_mem_q[res_rd_q];

  // Perpendicular means neither the same nor the opposite direction
  assign perp  = cls_i.det[0] != last_q[0];
  assign q_sum = (LIM_BITS + 1)'(quiet_q) + (LIM_BITS + 1)'(cls_i.elapsed);
  assign q_sat = (q_sum > (LIM_BITS + 1)'(cfg_i.rearm_quiet_limit)) ?
                 cfg_i.rearm_quiet_limit : q_sum[LIM_BITS-1:0];

  // Next gesture state and result for the head sample
  always_comb begin
    armed_d    = armed_q;
    ret_seen_d = ret_seen_q;
    quiet_d    = quiet_q;
    last_d     = last_q;
    res        = '0;
    if (cls_i.ok) begin
      if (!armed_q) begin
        if (!cls_i.suppress && cls_i.valid && perp) begin
          last_d     = cls_i.det;
          ret_seen_d = 1'b0;
          quiet_d    = '0;
          res.move_valid     = 1'b1;
          res.move_direction = cls_i.det;
        end else if (!ret_seen_q) begin
          if (cls_i.ret[last_q]) begin
            ret_seen_d = 1'b1;
            quiet_d    = '0;
          end
        end else if (cls_i.quiet) begin
          if (q_sat >= cfg_i.rearm_quiet_limit) begin
            armed_d    = 1'b1;
            ret_seen_d = 1'b0;
            quiet_d    = '0;
          end else begin
            quiet_d = q_sat;
          end
        end else begin
          quiet_d = '0;
        end
      end else if (!cls_i.suppress && cls_i.valid) begin
        last_d     = cls_i.det;
        armed_d    = 1'b0;
        ret_seen_d = 1'b0;
        quiet_d    = '0;
        res.move_valid     = 1'b1;
        res.move_direction = cls_i.det;
      end
    end
  end

  // Hold state; advance on each step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      ret_seen_q <= 1'b1;
      quiet_q    <= '0;
      last_q     <= DIR_UP;
    end else if (step) begin
      armed_q    <= armed_d;
      ret_seen_q <= ret_seen_d;
      quiet_q    <= quiet_d;
      last_q     <= last_d;
    end
  end

  // Result queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (step)    res_wr_q <= ~res_wr_q;
      if (res_pop) res_rd_q <= ~res_rd_q;
      case ({step, res_pop})
        2'b10:   res_cnt_q <= res_cnt_q + 2'd1;
        2'b01:   res_cnt_q <= res_cnt_q - 2'd1;
        default: ;
      endcase
    end
  end

  // Store result
  always_ff @(posedge clk_i) begin
    if (step) res_mem_q[res_wr_q] <= res;
  end

endmodule

`default_nettype wire

[sv/gyro_gesture_detector_unit.sv]
// Top level of the gyro gesture detector: registers, front, queue, back.
// Depends on ggd_pkg, ggd_regs, ggd_front, ggd_queue and ggd_back.
`default_nettype none

// Gyro gesture detector. Push one gyro sample per transfer; every sample,
// including a failed read, yields exactly one result in order on the pop
// side. A sample is classified on the cycle it is pushed and written into
// a two-entry queue; the gesture state machine takes one queued sample per
// cycle whenever its two-entry result queue has room, so the block sustains
// one sample per clock while results are popped; each sample is registered
// once in each queue. Thresholds are set through the APB port at byte
// address 4*i and must only be written while the block is idle.
module gyro_gesture_detector_unit
  import ggd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready,
  input  wire logic                 push,
  output logic                      full,
  input  sample_t                   sample_i,
  output logic                      empty,
  input  wire logic                 pop,
  output result_t                   result_o
);

  cfg_t cfg;
  cls_t cls_in, cls_head;
  logic cls_empty, cls_pop;

  ggd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ggd_front u_front (
    .sample_i (sample_i),
    .cfg_i    (cfg),
    .cls_o    (cls_in)
  );

  ggd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_in),
    .full_o  (full),
    .pop_i   (cls_pop),
    .empty_o (cls_empty),
    .data_o  (cls_head)
  );

  ggd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cls_empty_i (cls_empty),
    .cls_i       (cls_head),
    .cls_pop_o   (cls_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire
